// File: rtl/core/isb_pkg.sv
// Package for the indexed sequence buffer: sizes, opcode and status codes,
// and the control bundle that steers each storage cell. No dependencies.
package isb_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 64;

    localparam int DATA_W = 64;
    localparam int POS_W  = 7;
    localparam int OCC_W  = 7;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic load;
        logic shift_up;
        logic shift_down;
        logic rd_sel;
    } cell_ctrl_t;

endpackage

// File: rtl/core/isb_cell.sv
// One storage cell of the buffer row: holds a single entry and takes the
// new item, its lower neighbour or its upper neighbour. Uses isb_pkg.
module isb_cell
    import isb_pkg::*;
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [WORD_WIDTH-1:0] new_word,
    input  logic [WORD_WIDTH-1:0] lower_word,
    input  logic [WORD_WIDTH-1:0] upper_word,
    output logic [WORD_WIDTH-1:0] entry,
    output logic [WORD_WIDTH-1:0] rd_word
);

    logic [WORD_WIDTH-1:0] entry_reg;
    logic [WORD_WIDTH-1:0] entry_next;

    always_comb
    begin
        priority if (ctrl.load)
        begin
            entry_next = new_word;
        end
        else if (ctrl.shift_up)
        begin
            entry_next = lower_word;
        end
        else if (ctrl.shift_down)
        begin
            entry_next = upper_word;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry   = entry_reg;
    assign rd_word = ctrl.rd_sel ? entry_reg : '0;

endmodule

// File: rtl/core/indexed_sequence_buffer_unit.sv
// Top level of the indexed sequence buffer: a row of isb_cell instances,
// the request decoder and the result register. Uses isb_pkg.
//
// The buffer takes one request per clock cycle while not stalled and returns
// its result in the following cycle; every cell of the row moves in parallel,
// so an insert or remove takes equally long at any position. A request is
// accepted whenever the result register is empty or its item is being taken.
// Stored entries have no reset; only the count and the result valid flag do.
module indexed_sequence_buffer_unit
    import isb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [POS_W-1:0]  position,
    input  logic [DATA_W-1:0] data_word,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [DATA_W-1:0] read_word,
    output logic [OCC_W-1:0]  occupancy
);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  out_valid_reg;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic [DATA_W-1:0]     read_word_reg;
    logic [DATA_W-1:0]     read_word_next;
    logic [OCC_W-1:0]      occupancy_reg;

    logic                  accept;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  do_insert;
    logic                  do_remove;
    logic                  do_read;
    logic [WORD_WIDTH-1:0] word_in;
    logic [WORD_WIDTH-1:0] rd_any;

    cell_ctrl_t            ctrl      [DEPTH];
    logic [WORD_WIDTH-1:0] entry     [DEPTH];
    logic [WORD_WIDTH-1:0] cell_rd   [DEPTH];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign pos_ext  = CMP_W'(position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign word_in  = data_word[WORD_WIDTH-1:0];

    always_comb
    begin
        status_next = ST_OK;
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        do_read     = 1'b0;
        count_next  = count_reg;
        unique case (opcode)
            OP_INSERT:
            begin
                if (pos_ext > cnt_ext)
                begin
                    status_next = ST_RANGE;
                end
                else if (count_reg == CNT_W'(DEPTH))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_insert  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE, OP_READ:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    status_next = ST_RANGE;
                end
                else if (opcode == OP_READ)
                begin
                    do_read = 1'b1;
                end
                else
                begin
                    do_remove  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [CMP_W-1:0]      idx;
        logic [WORD_WIDTH-1:0] lower_w;
        logic [WORD_WIDTH-1:0] upper_w;

        assign idx = CMP_W'(i);

        assign ctrl[i].load       = accept && do_insert && (idx == pos_ext);
        assign ctrl[i].shift_up   = accept && do_insert && (idx > pos_ext);
        assign ctrl[i].shift_down = accept && do_remove && (idx >= pos_ext);
        assign ctrl[i].rd_sel     = do_read && (idx == pos_ext);

        if (i == 0)
        begin : g_lo_edge
            assign lower_w = entry[i];
        end
        else
        begin : g_lo
            assign lower_w = entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_hi_edge
            assign upper_w = entry[i];
        end
        else
        begin : g_hi
            assign upper_w = entry[i+1];
        end

        isb_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl[i]),
            .new_word   (word_in),
            .lower_word (lower_w),
            .upper_word (upper_w),
            .entry      (entry[i]),
            .rd_word    (cell_rd[i])
        );
    end

    always_comb
    begin
        rd_any = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            rd_any = rd_any | cell_rd[k];
        end
        read_word_next = DATA_W'(rd_any);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            read_word_reg <= read_word_next;
            occupancy_reg <= OCC_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign read_word = read_word_reg;
    assign occupancy = occupancy_reg;

endmodule
